>>> design/stv_pkg.sv
// Shared types and constants for the sepia tone with vignette block.
`default_nettype none
package stv_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    // Sepia coefficients in Q0.12 (rows: red, green, blue output; cols: r, g, b)
    localparam logic [11:0] COEF_RR = 12'd1610;
    localparam logic [11:0] COEF_RG = 12'd3150;
    localparam logic [11:0] COEF_RB = 12'd774;
    localparam logic [11:0] COEF_GR = 12'd1430;
    localparam logic [11:0] COEF_GG = 12'd2810;
    localparam logic [11:0] COEF_GB = 12'd688;
    localparam logic [11:0] COEF_BR = 12'd1114;
    localparam logic [11:0] COEF_BG = 12'd2187;
    localparam logic [11:0] COEF_BB = 12'd537;

    localparam int SUM_W    = 9;   // sepia sums stay at or below 344
    localparam int FACTOR_W = 13;  // Q0.12 factor, entry 0 is 4096
    localparam int CHAN_W   = 8;

    // Divider control handshake
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

>>> design/stv_front.sv
// Front end: pixel accept, raster counters, sepia sums and position terms.
`default_nettype none
module stv_front
    import stv_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [DIM_BITS-1:0] cfg_data,
    input  wire logic                pix_valid,
    input  wire logic [CHAN_W-1:0]   red_in,
    input  wire logic [CHAN_W-1:0]   green_in,
    input  wire logic [CHAN_W-1:0]   blue_in,
    input  wire logic                q_full,
    output logic                     pix_ready,
    output logic                     q_push,
    output logic [3*SUM_W+4*DIM_BITS+3-1:0] q_data
);

    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;

    logic [DIM_BITS-1:0] w_eff, h_eff;
    logic [DIM_BITS:0]   col_inc, row_inc;
    logic                col_last, row_last;
    logic                accept;
    logic signed [DIM_BITS+2:0] dx, dy;
    logic [DIM_BITS:0]   mag_x, mag_y;
    logic [21:0]         acc_r, acc_g, acc_b;
    logic [SUM_W-1:0]    sum_r, sum_g, sum_b;

    assign pix_ready = !q_full;
    assign accept    = pix_valid && !q_full;
    assign q_push    = accept;

    // Zero dimension acts as one
    assign w_eff = (width_reg == '0) ? DIM_BITS'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_BITS'(1) : height_reg;

    assign col_inc  = {1'b0, col_reg} + (DIM_BITS+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (DIM_BITS+1)'(1);
    assign col_last = col_inc >= {1'b0, w_eff};
    assign row_last = row_inc >= {1'b0, h_eff};

    // Offset from center, doubled: 2*pos - dim
    assign dx    = $signed({2'b00, col_reg, 1'b0}) - $signed({3'b000, w_eff});
    assign dy    = $signed({2'b00, row_reg, 1'b0}) - $signed({3'b000, h_eff});
    assign mag_x = dx[DIM_BITS+2] ? DIM_BITS'(0) + (DIM_BITS+1)'(-dx) : (DIM_BITS+1)'(dx);
    assign mag_y = dy[DIM_BITS+2] ? DIM_BITS'(0) + (DIM_BITS+1)'(-dy) : (DIM_BITS+1)'(dy);

    // Sepia sums, truncated
    assign acc_r = 22'(COEF_RR * red_in) + 22'(COEF_RG * green_in) + 22'(COEF_RB * blue_in);
    assign acc_g = 22'(COEF_GR * red_in) + 22'(COEF_GG * green_in) + 22'(COEF_GB * blue_in);
    assign acc_b = 22'(COEF_BR * red_in) + 22'(COEF_BG * green_in) + 22'(COEF_BB * blue_in);
    assign sum_r = acc_r[12+:SUM_W];
    assign sum_g = acc_g[12+:SUM_W];
    assign sum_b = acc_b[12+:SUM_W];

    // Item to the back end: sums, magnitudes, dimensions, frame end
    assign q_data = {sum_b, sum_g, sum_r, mag_y, mag_x, h_eff, w_eff,
                     col_last && row_last};

    // Register writes and counter advance
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                default:    width_next  = width_reg;
            endcase
        end
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_inc[DIM_BITS-1:0];
            end
            else
            begin
                col_next = col_inc[DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(750);
            height_reg <= DIM_BITS'(497);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule
`default_nettype wire

>>> design/stv_queue.sv
// Two-entry item queue between front and back end.
`default_nettype none
module stv_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic             wr_ptr_reg, wr_ptr_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> design/stv_div.sv
// Bit-serial restoring divider with quotient saturated at 2^QB.
`default_nettype none
module stv_div
    import stv_pkg::*;
#(
    parameter int NUM_W = 36,
    parameter int DEN_W = 24,
    parameter int QB    = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  div_ctrl_t             ctrl,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output div_stat_t             stat,
    output logic [QB:0]           quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [QB:0]      q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;
    logic             qbit;

    // One quotient bit per cycle
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign qbit  = trial >= {2'b00, den};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            num_next  = num;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            rem_next = qbit ? (DEN_W+1)'(trial - {2'b00, den}) : trial[DEN_W:0];
            // hold once the quotient reaches 2^QB
            q_next   = q_reg[QB] ? q_reg : {q_reg[QB-1:0], qbit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule
`default_nettype wire

>>> design/stv_back.sv
// Back end: distance, vignette lookup, scaling and result register.
`default_nettype none
module stv_back
    import stv_pkg::*;
#(
    parameter int DIM_BITS = 12,
    parameter int TB       = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire logic [3*SUM_W+4*DIM_BITS+3-1:0] q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [3*CHAN_W-1:0] out_data,
    output logic      out_last
);

    localparam int MAG_W = DIM_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int NUM_W = SQ_W + TB;
    localparam int DEN_W = 2 * DIM_BITS;
    localparam int DEPTH = 2 ** TB;

    typedef logic [FACTOR_W-1:0] rom_t [DEPTH];

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_LOOKUP = 5'b01000,
        ST_SCALE  = 5'b10000
    } state_t;

    function automatic logic [31:0] isqrt(input logic [31:0] n_in);
        logic [31:0] n, r, b;
        n = n_in;
        r = 0;
        b = 32'h4000_0000;
        for (int i = 0; i < 16; i++)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // True when v^10 <= c * 2^84
    function automatic logic tenth_fits(input logic [12:0] v, input logic [127:0] c);
        logic [127:0] p;
        p = 128'(v);
        for (int i = 0; i < 9; i++)
        begin
            p = p * 128'(v);
        end
        return p <= (c << 84);
    endfunction

    // Entry = floor(4096 * (1 - sqrt(idx / 2^TB))^0.3)
    function automatic rom_t build_rom();
        rom_t         t;
        logic [31:0]  s;
        logic [127:0] u, c;
        logic [12:0]  lo, hi, mid;
        for (int k = 0; k < DEPTH; k++)
        begin
            s  = isqrt(32'(k) << (24 - TB));
            u  = 128'(4096 - s);
            c  = u * u * u;
            lo = '0;
            hi = 13'd4096;
            for (int j = 0; j < 14; j++)
            begin
                if (lo < hi)
                begin
                    mid = 13'((14'(lo) + 14'(hi) + 14'd1) >> 1);
                    if (tenth_fits(mid, c))
                        lo = mid;
                    else
                        hi = mid - 13'd1;
                end
            end
            t[k] = lo;
        end
        return t;
    endfunction

    localparam rom_t VIG_ROM = build_rom();

    state_t state_reg, state_next;
    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg;
    logic              last_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [DEN_W-1:0]  w2_reg, h2_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic              out_valid_reg, out_valid_next;
    logic [3*CHAN_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [SUM_W-1:0]    q_sum_r, q_sum_g, q_sum_b;
    logic [MAG_W-1:0]    q_mag_x, q_mag_y;
    logic [DIM_BITS-1:0] q_w, q_h;
    logic                q_last;

    div_ctrl_t  div_ctrl;
    div_stat_t  stat_x, stat_y;
    logic [TB:0]   qx, qy;
    logic [TB+1:0] d2;
    logic          slot_free;
    logic [SUM_W+FACTOR_W-1:0] pr, pg, pb;

    function automatic logic [CHAN_W-1:0] sat8(input logic [SUM_W+FACTOR_W-1:0] p);
        logic [SUM_W+FACTOR_W-13:0] v;
        v = p[SUM_W+FACTOR_W-1:12];
        return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
    endfunction

    // Unpack the queued item
    assign {q_sum_b, q_sum_g, q_sum_r, q_mag_y, q_mag_x, q_h, q_w, q_last} = q_data;

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign div_ctrl.start = state_reg == ST_SQUARE;

    stv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(TB)) u_div_x (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (div_ctrl),
        .num  ({sqx_reg, TB'(0)}),
        .den  (w2_reg),
        .stat (stat_x),
        .quot (qx)
    );

    stv_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(TB)) u_div_y (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (div_ctrl),
        .num  ({sqy_reg, TB'(0)}),
        .den  (h2_reg),
        .stat (stat_y),
        .quot (qy)
    );

    assign d2 = {1'b0, qx} + {1'b0, qy};
    assign pr = (SUM_W+FACTOR_W)'(sum_r_reg * factor_reg);
    assign pg = (SUM_W+FACTOR_W)'(sum_g_reg * factor_reg);
    assign pb = (SUM_W+FACTOR_W)'(sum_b_reg * factor_reg);

    // Sequence one item through square, divide, lookup, scale
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_DIVIDE;
            ST_DIVIDE: if (stat_x.done && stat_y.done) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (slot_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers; squares are ready before the dividers start
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sum_r_reg <= q_sum_r;
            sum_g_reg <= q_sum_g;
            sum_b_reg <= q_sum_b;
            last_reg  <= q_last;
            sqx_reg   <= SQ_W'(q_mag_x * q_mag_x);
            sqy_reg   <= SQ_W'(q_mag_y * q_mag_y);
            w2_reg    <= DEN_W'(q_w * q_w);
            h2_reg    <= DEN_W'(q_h * q_h);
        end
        if (state_reg == ST_LOOKUP)
        begin
            factor_reg <= (d2[TB+1:TB] != 2'b00) ? '0 : VIG_ROM[d2[TB-1:0]];
        end
        if (state_reg == ST_SCALE && slot_free)
        begin
            out_data_reg <= {sat8(pb), sat8(pg), sat8(pr)};
            out_last_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

>>> design/sepia_tone_with_vignette.sv
// Top level of the sepia tone with radial vignette block.
// Usage:
//   Slave stream s_*: one RGB pixel per item in raster order.
//   Master stream m_*: one sepia, vignetted pixel per item; tlast marks the
//   last pixel of a frame (column and row both at their last position).
//   cfg_we/cfg_addr/cfg_data write image width (index 0) and height (1);
//   write only while the block is idle. A value of 0 acts as 1.
// Timing:
//   Each pixel's time in the back end is set by the two bit-serial distance
//   dividers, which run one quotient bit per cycle. One pixel is in work at a
//   time; a two-entry queue lets the front accept up to two more meanwhile.
// Reset:
//   Width 750, height 497, counters at the top-left pixel, streams empty.
// Stall:
//   A result waits in the output register while m_tready is low; the back
//   end finishes the next pixel and holds it until that register frees.
`default_nettype none
module sepia_tone_with_vignette
    import stv_pkg::*;
#(
    parameter int DIM_BITS            = 12,
    parameter int VIGNETTE_TABLE_BITS = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [DIM_BITS-1:0] cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,   // red_in, green_in, blue_in
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,   // red_out, green_out, blue_out
    output logic                     m_tlast    // frame_end
);

    localparam int ITEM_W = 3*SUM_W + 4*DIM_BITS + 3;

    logic              q_full, q_empty, q_push, q_pop;
    logic [ITEM_W-1:0] push_data, pop_data;

    stv_front #(.DIM_BITS(DIM_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .pix_valid(s_tvalid),
        .red_in   (s_tdata[7:0]),
        .green_in (s_tdata[15:8]),
        .blue_in  (s_tdata[23:16]),
        .q_full   (q_full),
        .pix_ready(s_tready),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    stv_queue #(.WIDTH(ITEM_W)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(push_data),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .pop_data (pop_data)
    );

    stv_back #(.DIM_BITS(DIM_BITS), .TB(VIGNETTE_TABLE_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule
`default_nettype wire

>>> dv/sepia_tone_with_vignette_test.sv
// Testbench for the sepia tone with radial vignette block.
`timescale 1ns / 1ps
module sepia_tone_with_vignette_test;
    import stv_pkg::*;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [11:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    pixel_t      expected_pixels[$];
    logic [12:0] vignette_table[1024];
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [11:0] column_pos;
    logic [11:0] row_pos;
    int          error_count;
    bit          source_gaps;
    bit          sink_stalls;
    int          stall_left;

    sepia_tone_with_vignette u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Build one vignette factor: floor(4096 * (1 - sqrt(d2 / 1024))^0.3) in Q0.12
    function automatic logic [12:0] vignette_factor(int d2);
        longint unsigned rad;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned u;
        bit [127:0]      limit;
        bit [127:0]      pw;
        rad = longint'(d2) << 14;
        lo = 0;
        hi = 4095;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= rad) lo = mid;
            else hi = mid - 1;
        end
        u = 4096 - lo;
        limit = 128'(u * u * u) << 84;
        lo = 0;
        hi = 4096;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            pw = 128'(mid * mid * mid * mid * mid);
            pw = pw * pw;
            if (pw <= limit) lo = mid;
            else hi = mid - 1;
        end
        return 13'(lo);
    endfunction

    function automatic longint unsigned distance_term(int pos, int dim);
        longint n;
        n = 2 * longint'(pos) - longint'(dim);
        if (n < 0) n = -n;
        return ((n * n) << 10) / (longint'(dim) * longint'(dim));
    endfunction

    function automatic logic [7:0] scale_channel(int sum, logic [12:0] factor);
        int v;
        v = (sum * int'(factor)) >> 12;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // Work out the expected pixel for an accepted input and advance position
    task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        int              w;
        int              h;
        int              sr;
        int              sg;
        int              sb;
        longint unsigned d2;
        logic [12:0]     factor;
        bit              col_last;
        bit              row_last;
        pixel_t          px;
        w = (frame_width == 0) ? 1 : int'(frame_width);
        h = (frame_height == 0) ? 1 : int'(frame_height);
        sr = (1610 * r + 3150 * g + 774 * b) >> 12;
        sg = (1430 * r + 2810 * g + 688 * b) >> 12;
        sb = (1114 * r + 2187 * g + 537 * b) >> 12;
        d2 = distance_term(column_pos, w) + distance_term(row_pos, h);
        factor = (d2 < 1024) ? vignette_table[d2] : 13'd0;
        col_last = int'(column_pos) + 1 >= w;
        row_last = int'(row_pos) + 1 >= h;
        px.red = scale_channel(sr, factor);
        px.green = scale_channel(sg, factor);
        px.blue = scale_channel(sb, factor);
        px.frame_end = col_last && row_last;
        expected_pixels.push_back(px);
        if (col_last)
        begin
            column_pos = 0;
            row_pos = row_last ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            column_pos = column_pos + 12'd1;
        end
    endtask

    // Offer one pixel, with an optional idle burst first, and hold until taken
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        do @(posedge clk); while (!s_tready);
        predict_pixel(r, g, b);
    endtask

    task automatic send_random_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) send_pixel(8'd255, 8'd255, 8'd255);
        else if (pick == 1) send_pixel(8'd0, 8'd0, 8'd0);
        else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop valid, drain all results and let the back end settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_dim(input reg_index_t idx, input logic [11:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH) frame_width = value;
        else frame_height = value;
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd64, 8'd32);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
    endtask

    // Small frame entered with the counter beyond the new width
    task automatic test_small_frame_extremes();
        write_dim(REG_WIDTH, 12'd3);
        write_dim(REG_HEIGHT, 12'd3);
        send_pixel(8'd255, 8'd255, 8'd255);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
    endtask

    task automatic test_zero_dims();
        write_dim(REG_WIDTH, 12'd0);
        write_dim(REG_HEIGHT, 12'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd50);
        drain();
    endtask

    // Largest frame, then shrink it while the column counter sits beyond the new width
    task automatic test_large_then_shrink();
        write_dim(REG_WIDTH, 12'd4095);
        write_dim(REG_HEIGHT, 12'd4095);
        for (int i = 0; i < 4; i++)
            send_pixel(8'd255, 8'd255, 8'd255);
        drain();
        write_dim(REG_WIDTH, 12'd1);
        write_dim(REG_HEIGHT, 12'd1);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255);
        drain();
    endtask

    // Mostly whole small frames, reconfigured between bursts
    task automatic test_random_frames(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 7) == 0)
                write_dim(REG_WIDTH, 12'($urandom_range(1, 4095)));
            else
                write_dim(REG_WIDTH, 12'($urandom_range(1, 24)));
            write_dim(REG_HEIGHT, 12'($urandom_range(0, 10)));
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                  : ((frame_width == 0 ? 1 : int'(frame_width)) *
                     (frame_height == 0 ? 1 : int'(frame_height)));
            if (burst > 120) burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
                send_random_pixel();
            sent += burst;
            drain();
        end
    endtask

    // Sink back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected pixel
    always @(posedge clk)
    begin
        pixel_t px;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected item: tdata %h tlast %b", m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                px = expected_pixels.pop_front();
                if (m_tdata[7:0] !== px.red)
                begin
                    $error("red_out expected %0d actual %0d", px.red, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== px.green)
                begin
                    $error("green_out expected %0d actual %0d", px.green, m_tdata[15:8]);
                    error_count++;
                end
                if (m_tdata[23:16] !== px.blue)
                begin
                    $error("blue_out expected %0d actual %0d", px.blue, m_tdata[23:16]);
                    error_count++;
                end
                if (m_tlast !== px.frame_end)
                begin
                    $error("frame_end expected %0d actual %0d", px.frame_end, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        stall_left = 0;
        error_count = 0;
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        frame_width = 12'd750;
        frame_height = 12'd497;
        column_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 1024; i++)
            vignette_table[i] = vignette_factor(i);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_small_frame_extremes();
        test_zero_dims();
        test_large_then_shrink();
        test_random_frames(560);
        // last part runs at full rate on both sides
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_frames(120);

        drain();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
